// File: rtl/core/bbd_pkg.sv
// Shared types and constants of the bilinear Bayer demosaic unit.
package bbd_pkg;

   localparam int unsigned PIX_W     = 8;
   localparam int unsigned ROW_W     = 13;
   localparam int unsigned HGT_W     = 12;
   localparam int unsigned CSR_W     = 13;
   localparam int unsigned FWID_W    = 12;
   localparam int unsigned MAX_ROWS  = 4096;
   localparam int unsigned ROW_SAT   = MAX_ROWS + 2;
   localparam int unsigned WIDTH_RST = 640;
   localparam int unsigned HGT_RST   = 480;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // position info of the result an item completes
   typedef struct packed {
      logic has_out;
      logic row_odd;
      logic col_odd;
      logic no_top;
      logic no_bot;
      logic no_left;
      logic no_right;
      logic last;
   } meta_type;

   typedef struct packed {
      logic      last;
      pixel_type blue;
      pixel_type green;
      pixel_type red;
   } rgb_type;

endpackage

// File: rtl/core/bbd_ram.sv
// Simple dual-port RAM with registered read, one write and one read port.
module bbd_ram #(
   parameter int unsigned DATA_W = 16,
   parameter int unsigned DEPTH  = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bayer_bilinear_demosaic_unit.sv
// Bilinear GBRG Bayer demosaic: line store RAM, 3x3 window, RGB output with skid.
// Path: a result goes to rsp through the stage 1, window and output registers, starting
// from the beat that completes its window (that beat comes one row plus one pixel after the result's own pixel).
// Throughput: 1 beat per cycle while the skid is empty; the line store RAM (read at
// accept, written back from stage 1) and the 3x3 window advance once per accepted beat.
// Reset: synchronous; clears counters, fill mark, window and handshake state, and loads the default frame size.
// Line store entries at or past the fill mark read as zero; there is no clearing pass.
module bayer_bilinear_demosaic_unit #(
   parameter int unsigned MAX_LINE = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // raw_pixel[7:0]
   input  logic                     req_tuser,   // drain
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [23:0]              rsp_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [0:0]               csr_addr,
   input  logic [bbd_pkg::CSR_W-1:0] csr_wdata
);

   import bbd_pkg::*;

   localparam int unsigned AW      = $clog2(MAX_LINE);
   localparam int unsigned FW      = $clog2(MAX_LINE + 1);
   localparam int unsigned W_RST   = (WIDTH_RST > MAX_LINE) ? MAX_LINE : WIDTH_RST;

   // configuration, stored clamped as size minus one
   logic [AW-1:0]    wid_m1_ff, wid_m1_in;
   logic [HGT_W-1:0] hgt_m1_ff, hgt_m1_in;

   // input position
   logic [AW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [FW-1:0]    fill_ff, fill_in;

   // stage 1: RAM read in flight
   logic             s1_valid_ff, s1_valid_in;
   meta_type         s1_meta_ff;
   logic [AW-1:0]    s1_col_ff;
   pixel_type        s1_pix_ff;
   logic             s1_fresh_ff;

   // stage 2: window holds the item
   logic             s2_valid_ff, s2_valid_in;
   meta_type         s2_meta_ff;
   pixel_type        win_ff [3][3];
   pixel_type        win_in [3][3];

   // output register and skid
   logic             out_valid_ff, out_valid_in;
   rgb_type          out_ff, out_in;
   logic             skid_valid_ff, skid_valid_in;
   rgb_type          skid_ff, skid_in;

   logic             en;
   logic             acc;
   meta_type         acc_meta;
   logic [ROW_W-1:0] orow;
   logic [AW-1:0]    ocol;
   logic             wrap;
   logic             push;
   logic [15:0]      ram_rd;
   pixel_type        up_v;
   pixel_type        mid_v;
   rgb_type          res;
   pixel_type        t_c, t_u, t_d, t_l, t_r, t_ul, t_ur, t_dl, t_dr;
   logic [8:0]       vert_s, horz_s;
   logic [9:0]       cross_s, diag_s;
   pixel_type        vert, horz, cross_avg, diag;
   logic [31:0]      fw32;
   logic [31:0]      fh32;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign acc        = req_tvalid && en;

   // ---------------- configuration ----------------
   always_comb begin
      wid_m1_in = wid_m1_ff;
      hgt_m1_in = hgt_m1_ff;
      fw32      = 32'(csr_wdata[FWID_W-1:0]);
      fh32      = 32'(csr_wdata);
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_FRAME_WIDTH: begin
               if (fw32 < 32'd2) begin
                  wid_m1_in = AW'(1);
               end else if (fw32 > MAX_LINE) begin
                  wid_m1_in = AW'(MAX_LINE - 1);
               end else begin
                  wid_m1_in = AW'(fw32 - 32'd1);
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (fh32 < 32'd2) begin
                  hgt_m1_in = HGT_W'(1);
               end else if (fh32 > MAX_ROWS) begin
                  hgt_m1_in = HGT_W'(MAX_ROWS - 1);
               end else begin
                  hgt_m1_in = HGT_W'(fh32 - 32'd1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- position of the accepted item ----------------
   always_comb begin
      orow = (col_ff == '0) ? (row_ff - ROW_W'(2)) : (row_ff - ROW_W'(1));
      ocol = (col_ff == '0) ? wid_m1_ff : (col_ff - AW'(1));
      wrap = (col_ff >= wid_m1_ff);
      acc_meta.has_out  = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
      acc_meta.row_odd  = orow[0];
      acc_meta.col_odd  = ocol[0];
      acc_meta.no_top   = (orow == '0);
      acc_meta.no_bot   = (orow >= ROW_W'(hgt_m1_ff));
      acc_meta.no_left  = (ocol == '0);
      acc_meta.no_right = (ocol >= wid_m1_ff);
      acc_meta.last     = acc_meta.no_bot && (ocol == wid_m1_ff);

      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (acc_meta.has_out && acc_meta.last) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            if (row_ff < ROW_W'(ROW_SAT)) begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   // ---------------- line store ----------------
   assign up_v  = s1_fresh_ff ? ram_rd[15:8] : '0;
   assign mid_v = s1_fresh_ff ? ram_rd[7:0]  : '0;

   bbd_ram #(
      .DATA_W (16),
      .DEPTH  (MAX_LINE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff && en),
      .wr_addr (s1_col_ff),
      .wr_data ({mid_v, s1_pix_ff}),
      .rd_en   (acc),
      .rd_addr (col_ff),
      .rd_data (ram_rd)
   );

   always_comb begin
      fill_in = fill_ff;
      if (s1_valid_ff && en && FW'(s1_col_ff) == fill_ff) begin
         fill_in = fill_ff + FW'(1);
      end
   end

   // ---------------- window ----------------
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            win_in[r][c] = win_ff[r][c];
         end
      end
      if (s1_valid_ff && en) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = up_v;
         win_in[1][2] = mid_v;
         win_in[2][2] = s1_pix_ff;
      end
   end

   // ---------------- interpolation ----------------
   always_comb begin
      t_c  = win_ff[1][1];
      t_u  = s2_meta_ff.no_top ? '0 : win_ff[0][1];
      t_d  = s2_meta_ff.no_bot ? '0 : win_ff[2][1];
      t_l  = s2_meta_ff.no_left ? '0 : win_ff[1][0];
      t_r  = s2_meta_ff.no_right ? '0 : win_ff[1][2];
      t_ul = (s2_meta_ff.no_top || s2_meta_ff.no_left) ? '0 : win_ff[0][0];
      t_ur = (s2_meta_ff.no_top || s2_meta_ff.no_right) ? '0 : win_ff[0][2];
      t_dl = (s2_meta_ff.no_bot || s2_meta_ff.no_left) ? '0 : win_ff[2][0];
      t_dr = (s2_meta_ff.no_bot || s2_meta_ff.no_right) ? '0 : win_ff[2][2];

      vert_s    = 9'(t_u) + 9'(t_d);
      horz_s    = 9'(t_l) + 9'(t_r);
      cross_s   = 10'(vert_s) + 10'(horz_s);
      diag_s    = 10'(t_ul) + 10'(t_ur) + 10'(t_dl) + 10'(t_dr);
      vert      = vert_s[8:1];
      horz      = horz_s[8:1];
      cross_avg = cross_s[9:2];
      diag      = diag_s[9:2];

      res.last = s2_meta_ff.last;
      unique case ({s2_meta_ff.row_odd, s2_meta_ff.col_odd})
         2'b00: begin
            res.red   = vert;
            res.green = t_c;
            res.blue  = horz;
         end
         2'b11: begin
            res.red   = horz;
            res.green = t_c;
            res.blue  = vert;
         end
         2'b01: begin
            res.red   = diag;
            res.green = cross_avg;
            res.blue  = t_c;
         end
         default: begin
            res.red   = t_c;
            res.green = cross_avg;
            res.blue  = diag;
         end
      endcase
   end

   // ---------------- output register and skid ----------------
   assign push = en && s2_valid_ff && s2_meta_ff.has_out;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || rsp_tready) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   assign s1_valid_in = en ? acc : s1_valid_ff;
   assign s2_valid_in = en ? s1_valid_ff : s2_valid_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.blue, out_ff.green, out_ff.red};
   assign rsp_tlast  = out_ff.last;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wid_m1_ff     <= AW'(W_RST - 1);
         hgt_m1_ff     <= HGT_W'(HGT_RST - 1);
         col_ff        <= '0;
         row_ff        <= '0;
         fill_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         wid_m1_ff     <= wid_m1_in;
         hgt_m1_ff     <= hgt_m1_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         fill_ff       <= fill_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= win_in[r][c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (acc) begin
         s1_meta_ff  <= acc_meta;
         s1_col_ff   <= col_ff;
         s1_pix_ff   <= req_tuser ? '0 : req_tdata;
         s1_fresh_ff <= (FW'(col_ff) < fill_ff);
      end
      if (en) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while output register is empty");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_LINE))
      else $error("line store fill mark beyond depth");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (acc && acc_meta.has_out && acc_meta.last) |=> (col_ff == '0 && row_ff == '0))
      else $error("position not cleared after frame end");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (!en && s2_valid_ff) |=> (s2_valid_ff && $stable(s2_meta_ff)))
      else $error("window stage moved while stalled");
`endif

endmodule
